### rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   // Request kinds carried in req_tuser.
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_BACK  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [7:0] BLANK_CHAR   = 8'h20;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

   // One screen cell: attribute in the high byte, character in the low byte.
   localparam int CELL_W  = 16;
   localparam int INDEX_W = 11;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } state_type;

endpackage

### rtl/tcw_screen_ram.sv
`timescale 1ns / 1ps

module tcw_screen_ram import tcw_pkg::*; #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/text_console_writer.sv
`timescale 1ns / 1ps

// Put, backspace and newline requests answer in the cycle after acceptance and may arrive every cycle
// while results are taken and no wipe runs. A cell read answers after the screen memory read register.
// A clear, a newline that runs off the last row, or a character that wraps past it writes every cell
// through the single memory write port, and no request is taken during this wipe.
// Reset homes the cursor and empties the result register; screen contents stay undefined
// until written, and no clearing pass runs after reset.
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code [7:0], fg_color [11:8], bg_color [15:12], cell_index [26:16], zero [31:27]
   input  logic [31:0] req_tdata,
   // req_type [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_char [7:0], cell_attr [15:8], cursor_col [22:16], cursor_row [27:23], zero [31:28]
   output logic [31:0] rsp_tdata
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS + 1);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int IDX_W      = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;

   state_type state_ff, state_in;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] sweep_ff;
   logic [CELL_W-1:0] fill_ff;
   logic [CELL_W-1:0] first_ff, first_in;
   logic              rd_ok_ff;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_char_ff, rsp_attr_ff;
   logic [6:0]        rsp_col_ff;
   logic [4:0]        rsp_row_ff;

   logic [7:0]         req_char;
   logic [7:0]         req_attr;
   logic [INDEX_W-1:0] req_index;
   logic               accept;
   logic               row_last;
   logic               col_full;
   logic               idx_ok;
   logic               sweep_done;

   logic [ROW_W-1:0]  tgt_row;
   logic [COL_W-1:0]  tgt_col;
   logic [ADDR_W-1:0] cursor_addr;
   logic              cell_wr;
   logic [CELL_W-1:0] cell_data;
   logic              start_sweep;
   logic              start_read;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [CELL_W-1:0] ram_rd_data;

   assign req_char  = req_tdata[7:0];
   assign req_attr  = {req_tdata[15:12], req_tdata[11:8]};
   assign req_index = req_tdata[26:16];

   assign accept     = req_tvalid && req_tready;
   assign row_last   = (row_ff == ROW_W'(ROWS - 1));
   assign col_full   = (col_ff >= COL_W'(COLUMNS));
   assign idx_ok     = (IDX_W'(req_index) < IDX_W'(CELL_COUNT));
   assign sweep_done = (sweep_ff == ADDR_W'(CELL_COUNT - 1));

   // Cursor update and the single cell write, wipe start or read start that a request causes.
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      tgt_row     = row_ff;
      tgt_col     = col_ff;
      cell_wr     = 1'b0;
      cell_data   = {req_attr, req_char};
      first_in    = {req_attr, BLANK_CHAR};
      start_sweep = 1'b0;
      start_read  = 1'b0;
      unique case (req_tuser)
         REQ_PUT: begin
            if (req_char == NEWLINE_CHAR) begin
               col_in = '0;
               if (row_last) begin
                  start_sweep = 1'b1;
                  row_in      = '0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else if (col_full) begin
               col_in = COL_W'(1);
               if (row_last) begin
                  // The wipe lands the character in the home cell.
                  start_sweep = 1'b1;
                  first_in    = {req_attr, req_char};
                  row_in      = '0;
               end else begin
                  row_in  = row_ff + 1'b1;
                  tgt_row = row_ff + 1'b1;
                  tgt_col = '0;
                  cell_wr = 1'b1;
               end
            end else begin
               cell_wr = 1'b1;
               col_in  = col_ff + 1'b1;
            end
         end
         REQ_BACK: begin
            if (col_ff != '0) begin
               col_in    = col_ff - 1'b1;
               tgt_col   = col_ff - 1'b1;
               cell_wr   = 1'b1;
               cell_data = {req_attr, BLANK_CHAR};
            end
         end
         REQ_CLEAR: begin
            start_sweep = 1'b1;
            col_in      = '0;
            row_in      = '0;
         end
         REQ_READ: begin
            start_read = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign cursor_addr = ADDR_W'(tgt_row) * ADDR_W'(COLUMNS) + ADDR_W'(tgt_col);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && start_sweep) begin
               state_in = ST_SWEEP;
            end else if (accept && start_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Handshake and memory port controls.
   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_addr;
      ram_wr_data = cell_data;
      ram_rd_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            ram_wr_en  = accept && cell_wr;
            ram_rd_en  = accept && start_read && idx_ok;
         end
         ST_READ: begin
         end
         ST_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = (sweep_ff == '0) ? first_ff : fill_ff;
         end
         default: begin
         end
      endcase
   end

   tcw_screen_ram #(
      .DEPTH  (CELL_COUNT),
      .ADDR_W (ADDR_W)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ADDR_W'(req_index)),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept && start_sweep) begin
            sweep_ff <= '0;
         end else if (state_ff == ST_SWEEP) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fill_ff  <= {req_attr, BLANK_CHAR};
         first_ff <= first_in;
         rd_ok_ff <= idx_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && !start_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (state_ff == ST_READ) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !start_read) begin
         rsp_char_ff <= '0;
         rsp_attr_ff <= '0;
         rsp_col_ff  <= 7'(col_in);
         rsp_row_ff  <= 5'(row_in);
      end else if (state_ff == ST_READ) begin
         // Reads beyond the screen answer with zeros.
         rsp_char_ff <= rd_ok_ff ? ram_rd_data[7:0] : 8'h00;
         rsp_attr_ff <= rd_ok_ff ? ram_rd_data[15:8] : 8'h00;
         rsp_col_ff  <= 7'(col_ff);
         rsp_row_ff  <= 5'(row_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_row_ff, rsp_col_ff, rsp_attr_ff, rsp_char_ff};

   // A request other than a read has its result ready on the next cycle.
   a_direct_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser != REQ_READ)) |=> rsp_tvalid)
      else $error("result missing after a non-read request");

   // A read produces its result through the ST_READ state, once the screen memory read has been registered.
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == REQ_READ)) |=> (!rsp_tvalid ##1 rsp_tvalid))
      else $error("read result not delivered on time");

   // No new result appears while the screen is being wiped.
   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared during a screen wipe");

   // The cursor row stays on the screen.
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff < ROW_W'(ROWS - 1)) || (row_ff == ROW_W'(ROWS - 1)))
      else $error("cursor row beyond the last row");

endmodule
